// ===== src/fca_pkg.sv =====
// ----------------------------------------------------------------------------
// fca_pkg
// shared constants, codes and controller/datapath interface types of the
// block link table allocator
// ----------------------------------------------------------------------------
package fca_pkg;

   localparam int NUM_BLOCKS_DEF       = 2048;
   localparam int FIRST_DATA_BLOCK_DEF = 10;
   localparam int BLOCK_W              = 11;
   localparam int CMD_W                = 2;
   localparam int STATUS_W             = 2;
   localparam int END_MARK             = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_FREE   = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_CUR,
      RD_SCAN,
      RD_LINK
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_FREE,
      WR_MARK,
      WR_LINK
   } wr_op_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_LINK,
      RES_SCAN
   } res_src_type;

   typedef struct packed {
      logic        load;
      rd_sel_type  rd_sel;
      wr_op_type   wr_op;
      logic        scan_inc;
      logic        walk_step;
      logic        res_ld;
      status_type  res_status;
      res_src_type res_src;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    in_range;
      logic    rd_zero;
      logic    rd_end;
      logic    rd_big;
      logic    steps_zero;
      logic    steps_last;
      logic    steps_full;
      logic    scan_last;
      logic    scan_none;
      logic    clear_last;
   } dp_stat_type;

endpackage

// ===== src/fca_dp.sv =====
// ----------------------------------------------------------------------------
// fca_dp
// datapath: link table memory, scan counter, chain walk registers and
// result registers
// ----------------------------------------------------------------------------
module fca_dp #(
   parameter int NUM_BLOCKS       = 2048,
   parameter int FIRST_DATA_BLOCK = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fca_pkg::CMD_W-1:0]         req_cmd,
   input  logic [fca_pkg::BLOCK_W-1:0]       req_start_block,
   input  fca_pkg::dp_cmd_type               cmd,
   output fca_pkg::dp_stat_type              stat,
   output logic [fca_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fca_pkg::BLOCK_W-1:0]       rsp_block
);
   import fca_pkg::*;

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = IDX_W + 1;
   localparam bit SCAN_NONE = FIRST_DATA_BLOCK >= NUM_BLOCKS;

   logic [IDX_W-1:0] mem [NUM_BLOCKS];

   cmd_type              cmd_ff;
   logic [BLOCK_W-1:0]   start_ff;
   logic [IDX_W-1:0]     cur_ff;
   logic [CNT_W-1:0]     steps_ff;
   logic [CNT_W-1:0]     scan_ff;
   logic [IDX_W-1:0]     found_ff;
   logic [IDX_W-1:0]     rd_data_ff;
   status_type           res_status_ff;
   logic [BLOCK_W-1:0]   res_block_ff;

   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     scan_prev;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     wr_data;

   assign scan_prev = IDX_W'(scan_ff - CNT_W'(1));

   always_comb begin
      case (cmd.rd_sel)
         RD_SCAN: rd_addr = scan_ff[IDX_W-1:0];
         RD_LINK: rd_addr = rd_data_ff;
         default: rd_addr = cur_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = cur_ff;
      wr_data = '0;
      case (cmd.wr_op)
         WR_CLEAR: wr_addr = scan_ff[IDX_W-1:0];
         WR_FREE:  wr_addr = cur_ff;
         WR_MARK: begin
            wr_addr = scan_prev;
            wr_data = IDX_W'(END_MARK);
         end
         WR_LINK: begin
            wr_addr = cur_ff;
            wr_data = found_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // write-first on a same-address read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.load) begin
         scan_ff <= CNT_W'(FIRST_DATA_BLOCK);
      end else if (cmd.scan_inc) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= cmd_type'(req_cmd);
         start_ff <= req_start_block;
         cur_ff   <= IDX_W'(req_start_block);
         steps_ff <= '0;
      end else if (cmd.walk_step) begin
         cur_ff   <= rd_data_ff;
         steps_ff <= steps_ff + CNT_W'(1);
      end
      if (cmd.wr_op == WR_MARK) begin
         found_ff <= scan_prev;
      end
      if (cmd.res_ld) begin
         res_status_ff <= cmd.res_status;
         case (cmd.res_src)
            RES_LINK: res_block_ff <= BLOCK_W'(rd_data_ff);
            RES_SCAN: res_block_ff <= BLOCK_W'(scan_prev);
            default:  res_block_ff <= '0;
         endcase
      end
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.in_range   = 32'(start_ff) < NUM_BLOCKS;
      stat.rd_zero    = rd_data_ff == '0;
      stat.rd_end     = rd_data_ff == IDX_W'(END_MARK);
      stat.rd_big     = CNT_W'(rd_data_ff) >= CNT_W'(NUM_BLOCKS);
      stat.steps_zero = steps_ff == '0;
      stat.steps_last = steps_ff == CNT_W'(NUM_BLOCKS - 1);
      stat.steps_full = steps_ff == CNT_W'(NUM_BLOCKS);
      stat.scan_last  = scan_ff == CNT_W'(NUM_BLOCKS);
      stat.scan_none  = SCAN_NONE;
      stat.clear_last = scan_ff == CNT_W'(NUM_BLOCKS - 1);
   end

   assign rsp_status = res_status_ff;
   assign rsp_block  = res_block_ff;

endmodule

// ===== src/fca_ctrl.sv =====
// ----------------------------------------------------------------------------
// fca_ctrl
// controller: sequences the clearing pass, link lookup, chain walks and the
// free-block scan, and raises busy and the result strobe
// ----------------------------------------------------------------------------
module fca_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  fca_pkg::dp_stat_type stat,
   output fca_pkg::dp_cmd_type  cmd
);
   import fca_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_READ,
      S_FREE,
      S_APPEND,
      S_SCAN,
      S_LINK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      done;

   always_comb begin
      state_in       = state_ff;
      done           = 1'b0;
      cmd.load       = 1'b0;
      cmd.rd_sel     = RD_CUR;
      cmd.wr_op      = WR_NONE;
      cmd.scan_inc   = 1'b0;
      cmd.walk_step  = 1'b0;
      cmd.res_ld     = 1'b0;
      cmd.res_status = ST_OK;
      cmd.res_src    = RES_ZERO;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_op    = WR_CLEAR;
            cmd.scan_inc = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            case (stat.cmd)
               CMD_ALLOC: begin
                  cmd.rd_sel   = RD_SCAN;
                  cmd.scan_inc = 1'b1;
                  state_in     = S_SCAN;
               end
               CMD_APPEND: state_in = S_APPEND;
               CMD_FREE:   state_in = S_FREE;
               default:    state_in = S_READ;
            endcase
         end
         S_READ: begin
            cmd.res_ld = 1'b1;
            if (stat.in_range) begin
               cmd.res_src = RES_LINK;
            end else begin
               cmd.res_status = ST_BAD;
            end
            done     = 1'b1;
            state_in = S_IDLE;
         end
         S_FREE: begin
            if (stat.steps_zero && (!stat.in_range || stat.rd_zero)) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_BAD;
               done           = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.wr_op = WR_FREE;
               if (stat.rd_end || stat.rd_zero || stat.rd_big || stat.steps_last) begin
                  cmd.res_ld = 1'b1;
                  done       = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.walk_step = 1'b1;
                  cmd.rd_sel    = RD_LINK;
               end
            end
         end
         S_APPEND: begin
            if (!stat.in_range) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_BAD;
               done           = 1'b1;
               state_in       = S_IDLE;
            end else if (stat.rd_end) begin
               cmd.rd_sel   = RD_SCAN;
               cmd.scan_inc = 1'b1;
               state_in     = S_SCAN;
            end else if (stat.rd_zero || stat.rd_big || stat.steps_full) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_BAD;
               done           = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
               cmd.rd_sel    = RD_LINK;
            end
         end
         S_SCAN: begin
            if (stat.scan_none) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_FULL;
               done           = 1'b1;
               state_in       = S_IDLE;
            end else if (stat.rd_zero) begin
               cmd.wr_op   = WR_MARK;
               cmd.res_ld  = 1'b1;
               cmd.res_src = RES_SCAN;
               if (stat.cmd == CMD_APPEND) begin
                  state_in = S_LINK;
               end else begin
                  done     = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.scan_last) begin
               cmd.res_ld     = 1'b1;
               cmd.res_status = ST_FULL;
               done           = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.rd_sel   = RD_SCAN;
               cmd.scan_inc = 1'b1;
            end
         end
         S_LINK: begin
            cmd.wr_op = WR_LINK;
            done      = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= state_in != S_IDLE;
         rsp_valid_ff <= done;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("busy not raised after accepted transaction");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!busy_ff && state_ff == S_IDLE))
      else $error("result strobe while still busy");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!rsp_valid_ff && busy_ff))
      else $error("activity during table clearing");
`endif

endmodule

// ===== src/fat_chain_allocator.sv =====
// ----------------------------------------------------------------------------
// fat_chain_allocator
// block link table with allocate, append, free and read-link commands
//
//   channel   ports                               handshake
//   request   req_cmd, req_start_block            start && !busy
//   response  rsp_status, rsp_block               rsp_valid, one cycle
//
// the link table sits in a single-port-write, single-port-read memory and is
// visited one entry per cycle: read looks up the start block's link, free
// walks the chain and clears it, allocate scans for a free entry and marks
// it as a chain end, append adds the chain walk and one link write. after
// reset a table clearing pass holds busy high. responses cannot be stalled.
// ----------------------------------------------------------------------------
module fat_chain_allocator #(
   parameter int NUM_BLOCKS       = fca_pkg::NUM_BLOCKS_DEF,
   parameter int FIRST_DATA_BLOCK = fca_pkg::FIRST_DATA_BLOCK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fca_pkg::CMD_W-1:0]     req_cmd,
   input  logic [fca_pkg::BLOCK_W-1:0]   req_start_block,
   output logic                          rsp_valid,
   output logic [fca_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fca_pkg::BLOCK_W-1:0]   rsp_block
);
   import fca_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   fca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   fca_dp #(
      .NUM_BLOCKS       (NUM_BLOCKS),
      .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_cmd),
      .req_start_block (req_start_block),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .rsp_status      (rsp_status),
      .rsp_block       (rsp_block)
   );

endmodule
